FILE: src/rlm_pkg.sv
package rlm_pkg;

    // Default block length limit.
    localparam int MAX_BLOCK_DEF = 4096;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int Q16_W      = 17;
    localparam int ALPHA_W    = 17;
    localparam int GAIN_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam int M_TDATA_W  = 40;

    // Square root datapath: a 34-bit radicand resolved two bits per step.
    localparam int RAD_W      = 34;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQ_REM_W   = 20;

    // Shared multiplier, 17 by 17 bits.
    localparam int PROD_W     = 2 * Q16_W;
    localparam int SQUARE_W   = 31;
    localparam int LVL_SUM_W  = PROD_W;

    // Fixed-point constants.
    localparam logic [Q16_W-1:0]   ONE_Q16   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd22938;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 10'd384;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 8'd1;

    // Request kinds carried in s_tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_DIV,
        ST_SQRT_MS,
        ST_SQRT_RMS,
        ST_GAIN,
        ST_NORM,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

FILE: src/rms_level_meter_core.sv
// RMS level meter. Signed 16-bit samples stream in on the s_ channel, one request per
// sample, with s_tlast on the last sample of a block; a block also ends by itself once
// it holds MAX_BLOCK samples. A sample that does not end a block leaves s_tready high,
// so such samples can follow back to back. A block end closes the input while a
// single compare-subtract unit works bit-serially, first through the mean-square
// division (one quotient bit per cycle) and then through two square roots (two radicand
// bits per cycle), after which one shared 17x17 multiplier applies the gain and the
// smoothing in the gain, norm, multiply and add states. A clear request (s_tuser high)
// zeroes the meter and reports zero through the emit state. Each result carries the
// smoothed level and the block's RMS as unsigned Q1.16; the block holds each result in
// an output register, and a new result waits in the emit state while that register
// still holds an untaken result and m_tready is low.
module rms_level_meter_core #(
    parameter int MAX_BLOCK = rlm_pkg::MAX_BLOCK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Sample requests.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlm_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample
    input  logic                              s_tlast,   // block_end
    input  logic                              s_tuser,   // [0] command
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlm_pkg::M_TDATA_W-1:0]     m_tdata,   // [16:0] level, [33:17] rms_value
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rlm_pkg::*;

    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W    = 30 + CNT_W;
    localparam int DVD_W    = SUM_W + 2;
    localparam int UNIT_W   = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
    localparam int STEP_W   = $clog2(DVD_W);
    localparam int PAD_W    = M_TDATA_W - 2 * Q16_W;

    // Control and state registers.
    state_t              state_reg, state_next;
    logic [ALPHA_W-1:0]  alpha_reg, alpha_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [Q16_W-1:0]    smooth_reg, smooth_next;
    logic                sq_valid_reg, sq_valid_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic [SQUARE_W-1:0] sq_reg, sq_next;
    logic [DVD_W-1:0]    div_q_reg, div_q_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [UNIT_W-1:0]   rem_reg, rem_next;
    logic [Q16_W-1:0]    root_reg, root_next;
    logic [Q16_W-1:0]    rms_reg, rms_next;
    logic [Q16_W-1:0]    norm_reg, norm_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-2:0]   acc_reg, acc_next;
    logic [Q16_W-1:0]    res_level_reg, res_level_next;
    logic [Q16_W-1:0]    res_rms_reg, res_rms_next;
    logic [Q16_W-1:0]    m_level_reg, m_level_next;
    logic [Q16_W-1:0]    m_rms_reg, m_rms_next;

    // Combinational helpers.
    logic                s_acc, is_clear, out_free, blk_full;
    logic [CNT_W:0]      cnt_inc;
    logic [Q16_W-1:0]    mag;
    logic [SUM_W-1:0]    sum_acc;
    logic [UNIT_W-1:0]   unit_a, unit_b, unit_res;
    logic [UNIT_W:0]     unit_diff;
    logic                unit_ge;
    logic [Q16_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [Q16_W-1:0]    alpha_eff, one_minus;
    logic [PROD_W-9:0]   gain_shr;
    logic [LVL_SUM_W-1:0] lvl_sum;
    logic                div_last, sqrt_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, m_rms_reg, m_level_reg};

    assign s_acc    = s_tvalid && s_tready;
    assign is_clear = (s_tuser == CMD_CLEAR);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_inc  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign blk_full = (cnt_inc >= (CNT_W + 1)'(MAX_BLOCK));
    assign div_last  = (step_reg == STEP_W'(DVD_W - 1));
    assign sqrt_last = (step_reg == STEP_W'(SQRT_STEPS - 1));

    // Magnitude of the two's complement sample; full negative scale gives 32768.
    assign mag = s_tdata[SAMPLE_W-1] ? (ONE_Q16 - Q16_W'(s_tdata)) : Q16_W'(s_tdata);

    // Running sum with the pending square folded in.
    assign sum_acc = sq_valid_reg ? (sum_reg + SUM_W'(sq_reg)) : sum_reg;

    // Alpha above one acts as one.
    assign alpha_eff = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign one_minus = ONE_Q16 - alpha_eff;

    // Shared compare-subtract unit: a division step or a square root step.
    always_comb begin
        if (state_reg == ST_DIV) begin
            unit_a = UNIT_W'({rem_reg[CNT_W-1:0], div_q_reg[DVD_W-1]});
            unit_b = UNIT_W'(count_reg);
        end else begin
            unit_a = UNIT_W'({rem_reg[SQ_REM_W-3:0], rad_reg[RAD_W-1 -: 2]});
            unit_b = UNIT_W'({root_reg, 2'b01});
        end
    end

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = !unit_diff[UNIT_W];
    assign unit_res  = unit_ge ? unit_diff[UNIT_W-1:0] : unit_a;

    // Shared multiplier operand selection.
    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                mul_a = mag;
                mul_b = mag;
            end
            ST_GAIN: begin
                mul_a = root_reg;
                mul_b = Q16_W'(gain_reg);
            end
            ST_MUL_NEW: begin
                mul_a = norm_reg;
                mul_b = alpha_eff;
            end
            ST_MUL_OLD: begin
                mul_a = smooth_reg;
                mul_b = one_minus;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign gain_shr = prod_reg[PROD_W-1:8];
    assign lvl_sum  = {1'b0, acc_reg} + {1'b0, prod_reg[PROD_W-2:0]};

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (is_clear) begin
                        state_next = ST_EMIT;
                    end else if (s_tlast || blk_full) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:    state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_SQRT_MS;
                end
            end
            ST_SQRT_MS: begin
                if (sqrt_last) begin
                    state_next = ST_SQRT_RMS;
                end
            end
            ST_SQRT_RMS: begin
                if (sqrt_last) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:     state_next = ST_NORM;
            ST_NORM:     state_next = ST_MUL_NEW;
            ST_MUL_NEW:  state_next = ST_MUL_OLD;
            ST_MUL_OLD:  state_next = ST_ADD;
            ST_ADD:      state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        alpha_next     = alpha_reg;
        gain_next      = gain_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        smooth_next    = smooth_reg;
        sq_valid_next  = sq_valid_reg;
        sq_next        = sq_reg;
        step_next      = step_reg;
        div_q_next     = div_q_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        rms_next       = rms_reg;
        norm_next      = norm_reg;
        acc_next       = acc_reg;
        res_level_next = res_level_reg;
        res_rms_next   = res_rms_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_level_next   = m_level_reg;
        m_rms_next     = m_rms_reg;

        // Configuration writes; indexes past the list are dropped.
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_ALPHA) begin
                alpha_next = cfg_data[ALPHA_W-1:0];
            end else if (cfg_index == REG_GAIN) begin
                gain_next = cfg_data[GAIN_W-1:0];
            end
        end

        // The output register drains whenever the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // Fold the previous square in, square the new sample.
                sum_next      = sum_acc;
                sq_valid_next = 1'b0;
                if (s_acc) begin
                    if (is_clear) begin
                        sum_next       = '0;
                        count_next     = '0;
                        smooth_next    = '0;
                        res_level_next = '0;
                        res_rms_next   = '0;
                    end else begin
                        sq_next       = mul_p[SQUARE_W-1:0];
                        sq_valid_next = 1'b1;
                        count_next    = cnt_inc[CNT_W-1:0];
                    end
                end
            end
            ST_FLUSH: begin
                // Mean square dividend is four times the finished sum.
                div_q_next    = {sum_acc, 2'b00};
                sum_next      = '0;
                sq_valid_next = 1'b0;
                rem_next      = '0;
                step_next     = '0;
            end
            ST_DIV: begin
                rem_next   = unit_res;
                div_q_next = {div_q_reg[DVD_W-2:0], unit_ge};
                step_next  = step_reg + STEP_W'(1);
                if (div_last) begin
                    rad_next  = {1'b0, div_q_next[RAD_W-2:0]};
                    rem_next  = '0;
                    root_next = '0;
                    step_next = '0;
                end
            end
            ST_SQRT_MS, ST_SQRT_RMS: begin
                rem_next  = unit_res;
                root_next = {root_reg[Q16_W-2:0], unit_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (sqrt_last) begin
                    step_next = '0;
                    if (state_reg == ST_SQRT_MS) begin
                        // Second root runs on rms scaled to Q1.32.
                        rms_next  = root_next;
                        rad_next  = {1'b0, root_next, 16'd0};
                        rem_next  = '0;
                        root_next = '0;
                    end
                end
            end
            ST_NORM: begin
                // Gain product is Q3.24; drop to Q1.16 and clamp at one.
                norm_next = (gain_shr > (PROD_W - 8)'(ONE_Q16)) ?
                            ONE_Q16 : gain_shr[Q16_W-1:0];
            end
            ST_MUL_OLD: begin
                acc_next = prod_reg[PROD_W-2:0];
            end
            ST_ADD: begin
                smooth_next    = lvl_sum[Q16_W+15:16];
                res_level_next = lvl_sum[Q16_W+15:16];
                res_rms_next   = rms_reg;
                count_next     = '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_level_next  = res_level_reg;
                    m_rms_next    = res_rms_reg;
                end
            end
            default: begin
                step_next = step_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            alpha_reg    <= ALPHA_RST;
            gain_reg     <= GAIN_RST;
            sum_reg      <= '0;
            count_reg    <= '0;
            smooth_reg   <= '0;
            sq_valid_reg <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            alpha_reg    <= alpha_next;
            gain_reg     <= gain_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            smooth_reg   <= smooth_next;
            sq_valid_reg <= sq_valid_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sq_reg        <= sq_next;
        div_q_reg     <= div_q_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        rms_reg       <= rms_next;
        norm_reg      <= norm_next;
        prod_reg      <= mul_p;
        acc_reg       <= acc_next;
        res_level_reg <= res_level_next;
        res_rms_reg   <= res_rms_next;
        m_level_reg   <= m_level_next;
        m_rms_reg     <= m_rms_next;
    end

endmodule

FILE: src/rlm_checker.sv
module rlm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rlm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rlm_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Level and RMS never exceed full scale.
    a_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:0] <= ONE_Q16) && (m_tdata[33:17] <= ONE_Q16))
        else $error("result above full scale");

    // Padding bits of the result stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:34] == '0))
        else $error("result padding not zero");

    // A clear or a flagged block end keeps the input closed on the next cycle.
    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_CLEAR || s_tlast) |=> !s_tready)
        else $error("request taken while result is being computed");

endmodule

bind rms_level_meter_core rlm_checker u_rlm_checker (.*);

FILE: test/rlm_meter_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels of the level meter,
// predicts every reading from the accepted requests and compares it with what
// the block delivers.
module rlm_meter_checker #(
    parameter int MAX_BLOCK = rlm_pkg::MAX_BLOCK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rlm_pkg::SAMPLE_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rlm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                error_count,
    output int                                results_pending
);
    import rlm_pkg::*;

    typedef struct packed {
        logic [Q16_W-1:0] level;
        logic [Q16_W-1:0] rms;
    } meter_reading_t;

    // Readings still owed by the block, oldest first.
    meter_reading_t expected_readings[$];

    // Shadow copy of the meter state and its registers.
    logic [42:0]        acc_sum;
    logic [12:0]        acc_count;
    logic [Q16_W-1:0]   held_level;
    logic [ALPHA_W-1:0] alpha_q;
    logic [GAIN_W-1:0]  gain_q;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        // Keep the log short when the block is badly broken.
        if (error_count < 50) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got_v, want_v);
        end
        error_count++;
    endtask

    // Largest r with r*r <= v, found by bisection.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'd1 << 23;
        while (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Reading produced when a block closes: mean square, RMS, fourth root with
    // gain and clamp, then the smoothing step.
    function automatic meter_reading_t close_block(
        input logic [42:0]        sum,
        input logic [12:0]        count,
        input logic [Q16_W-1:0]   prev,
        input logic [ALPHA_W-1:0] alpha,
        input logic [GAIN_W-1:0]  gain
    );
        logic [63:0]    mean_sq;
        logic [63:0]    rms_w;
        logic [63:0]    root_w;
        logic [63:0]    norm_w;
        logic [63:0]    weight;
        logic [63:0]    lvl_w;
        meter_reading_t r;
        mean_sq = ({21'd0, sum} << 2) / {51'd0, count};
        rms_w   = floor_sqrt(mean_sq);
        root_w  = floor_sqrt(rms_w << 16);
        norm_w  = (root_w * {54'd0, gain}) >> 8;
        if (norm_w > 64'd65536) begin
            norm_w = 64'd65536;
        end
        // An alpha above one acts as one.
        weight = (alpha > ONE_Q16) ? 64'd65536 : {47'd0, alpha};
        lvl_w  = ({47'd0, prev} * (64'd65536 - weight) + norm_w * weight) >> 16;
        r.level = lvl_w[Q16_W-1:0];
        r.rms   = rms_w[Q16_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        meter_reading_t got;
        meter_reading_t want;
        meter_reading_t fresh;
        logic [63:0]    mag;
        logic [63:0]    square;
        if (!aresetn) begin
            expected_readings.delete();
            acc_sum     = '0;
            acc_count   = '0;
            held_level  = '0;
            alpha_q     = ALPHA_RST;
            gain_q      = GAIN_RST;
            error_count = 0;
        end else begin
            // Register writes; unknown indexes are dropped.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ALPHA) begin
                    alpha_q = cfg_data[ALPHA_W-1:0];
                end else if (cfg_index == REG_GAIN) begin
                    gain_q = cfg_data[GAIN_W-1:0];
                end
            end

            // Compare each delivered reading with the oldest one owed.
            if (m_tvalid && m_tready) begin
                got.level = m_tdata[Q16_W-1:0];
                got.rms   = m_tdata[2*Q16_W-1:Q16_W];
                if (expected_readings.size() == 0) begin
                    report_mismatch("reading with none pending, level", int'(got.level), 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.level !== want.level) begin
                        report_mismatch("level", int'(got.level), int'(want.level));
                    end
                    if (got.rms !== want.rms) begin
                        report_mismatch("rms_value", int'(got.rms), int'(want.rms));
                    end
                end
            end

            // Advance the shadow meter on every accepted request.
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_CLEAR) begin
                    acc_sum    = '0;
                    acc_count  = '0;
                    held_level = '0;
                    fresh      = '0;
                    expected_readings.push_back(fresh);
                end else begin
                    mag = s_tdata[SAMPLE_W-1] ? (64'h10000 - {48'd0, s_tdata})
                                              : {48'd0, s_tdata};
                    square    = mag * mag;
                    acc_sum   = acc_sum + square[42:0];
                    acc_count = acc_count + 13'd1;
                    // A block closes on its flag or when it is full.
                    if (s_tlast || int'(acc_count) >= MAX_BLOCK) begin
                        fresh = close_block(acc_sum, acc_count, held_level, alpha_q, gain_q);
                        held_level = fresh.level;
                        acc_sum    = '0;
                        acc_count  = '0;
                        expected_readings.push_back(fresh);
                    end
                end
            end
        end
        results_pending <= expected_readings.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import rlm_pkg::*;

    localparam int MAX_BLOCK     = MAX_BLOCK_DEF;
    localparam int RAND_ITEMS    = 1150;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;     // [15:0] sample
    logic                  s_tlast;     // block_end
    logic                  s_tuser;     // [0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // [16:0] level, [33:17] rms_value
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    error_count;
    int                    results_pending;

    rms_level_meter_core #(
        .MAX_BLOCK (MAX_BLOCK)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rlm_meter_checker #(
        .MAX_BLOCK (MAX_BLOCK)
    ) meter_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always #10 aclk = ~aclk;

    // Give up at a time far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: a random stall before each reading, calm stretches without
    // stalls, and two long holds that back the block up into its input.
    initial begin : result_sink
        int stall;
        int taken;
        bit calm;
        m_tready <= 1'b0;
        taken = 0;
        calm  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 16 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 4);
            if (taken == 30 || taken == 300) begin
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            taken++;
        end
    end

    // Offers one request after a random gap and waits until it is taken.
    // The valid stays high afterwards; the caller lowers it when done.
    task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                                input logic last, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Writes one register; the caller lowers cfg_valid after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Waits until every owed reading has arrived and the block has settled.
    task automatic wait_idle();
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register settings per phase, extremes first.
    task automatic program_phase(input int phase);
        case (phase)
            0: begin
                write_register(REG_ALPHA, 17'd65536);
                write_register(REG_GAIN, 17'd1023);
            end
            1: begin
                write_register(REG_ALPHA, 17'd0);
                write_register(REG_GAIN, 17'd0);
            end
            2: begin
                // Alpha above one is treated as one.
                write_register(REG_ALPHA, 17'h1FFFF);
                write_register(REG_GAIN, 17'd256);
            end
            3: begin
                write_register(REG_ALPHA, 17'd1);
                write_register(REG_GAIN, 17'd1);
            end
            4: begin
                // Full-width random data; the gain keeps its low bits only.
                write_register(REG_ALPHA, CFG_DATA_W'($urandom));
                write_register(REG_GAIN, CFG_DATA_W'($urandom));
            end
            default: begin
                // Writes to unused indexes must leave the meter alone.
                write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
                write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
                write_register(REG_ALPHA, ALPHA_RST);
                write_register(REG_GAIN, CFG_DATA_W'(GAIN_RST));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // One random block of samples ending on the flag, sometimes cut by a clear,
    // or a lone clear request.
    task automatic send_random_block(inout int sent);
        int len;
        int pick;
        int style;
        bit calm;
        bit cut;
        logic [SAMPLE_W-1:0] smp;
        calm = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 24) == 0) begin
            send_request(CMD_CLEAR, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)), calm);
            sent++;
        end else begin
            pick  = $urandom_range(0, 99);
            len   = (pick < 85) ? $urandom_range(1, 8) :
                    (pick < 98) ? $urandom_range(9, 48) : $urandom_range(100, 300);
            style = $urandom_range(0, 4);
            cut   = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++) begin
                case (style)
                    0: smp = SAMPLE_W'($urandom);
                    1: smp = SAMPLE_W'($urandom_range(0, 511) - 256);
                    2: begin
                        case ($urandom_range(0, 5))
                            0: smp = 16'h8000;
                            1: smp = 16'h7FFF;
                            2: smp = 16'h8001;
                            3: smp = 16'hFFFF;
                            4: smp = 16'h0001;
                            default: smp = 16'h0000;
                        endcase
                    end
                    3: begin
                        smp = SAMPLE_W'($urandom_range(24000, 32767));
                        if ($urandom_range(0, 1) == 1) begin
                            smp = 16'd0 - smp;
                        end
                    end
                    default: smp = SAMPLE_W'($urandom_range(0, 15));
                endcase
                if (cut && i == len / 2) begin
                    send_request(CMD_CLEAR, SAMPLE_W'($urandom),
                                 1'($urandom_range(0, 1)), calm);
                    sent++;
                end
                send_request(CMD_SAMPLE, smp, i == len - 1, calm);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int sent;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= CMD_SAMPLE;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset settings of the registers.
        send_request(CMD_CLEAR, 16'h1234, 1'b0, 1'b0);
        send_request(CMD_SAMPLE, 16'h0000, 1'b1, 1'b0);
        send_request(CMD_SAMPLE, 16'h8000, 1'b1, 1'b0);
        send_request(CMD_SAMPLE, 16'h7FFF, 1'b1, 1'b0);
        send_request(CMD_SAMPLE, 16'h0001, 1'b0, 1'b0);
        send_request(CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0);
        // A clear in the middle of a block, with the block-end flag set.
        send_request(CMD_SAMPLE, 16'h5555, 1'b0, 1'b0);
        send_request(CMD_CLEAR, 16'hAAAA, 1'b1, 1'b0);
        send_request(CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0);
        send_request(CMD_SAMPLE, 16'd100, 1'b0, 1'b1);
        send_request(CMD_SAMPLE, 16'hFF38, 1'b0, 1'b1);
        send_request(CMD_SAMPLE, 16'd300, 1'b1, 1'b1);
        // A full block of full-scale samples closes without the flag.
        for (int n = 0; n < MAX_BLOCK; n++) begin
            send_request(CMD_SAMPLE, 16'h8000, 1'b0, 1'b1);
        end
        send_request(CMD_SAMPLE, 16'h3039, 1'b1, 1'b0);
        s_tvalid <= 1'b0;
        wait_idle();

        // Random blocks under several register settings.
        sent = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            program_phase(phase);
            while (sent < (phase + 1) * RAND_ITEMS / PHASES) begin
                send_random_block(sent);
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end

        if (error_count == 0 && results_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
